// ===== rtl/core/cfd_pkg.sv =====
// Shared constants and types for the coordinate frame deframer.
package cfd_pkg;

  localparam logic [7:0]  START_BYTE = 8'h12;
  localparam logic [7:0]  END_BYTE   = 8'h34;
  localparam logic [7:0]  FRAME_ID   = 8'h60;
  localparam logic [7:0]  FRAME_LEN  = 8'h06;
  localparam logic [15:0] CRC_POLY   = 16'h1021;

  // Byte positions within a frame, counted after the start byte
  localparam logic [3:0] POS_ID      = 4'd0;
  localparam logic [3:0] POS_LEN     = 4'd1;
  localparam logic [3:0] POS_X_HI    = 4'd2;
  localparam logic [3:0] POS_X_LO    = 4'd3;
  localparam logic [3:0] POS_Y_HI    = 4'd4;
  localparam logic [3:0] POS_Y_LO    = 4'd5;
  localparam logic [3:0] POS_HDG_HI  = 4'd6;
  localparam logic [3:0] POS_HDG_LO  = 4'd7;
  localparam logic [3:0] POS_ID_REP  = 4'd8;
  localparam logic [3:0] POS_CRC_HI  = 4'd9;
  localparam logic [3:0] POS_CRC_LO  = 4'd10;
  localparam logic [3:0] POS_END     = 4'd11;

  typedef struct packed {
    logic               frame_ok;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic        [15:0] heading;
  } result_t;

endpackage

// ===== rtl/core/cfd_channels.sv =====
// Handshake channels: received byte stream and decoded frame results.
interface cfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfd_result_if;
  logic               valid;
  logic               ready;
  logic               frame_ok;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic        [15:0] heading;

  modport source (output valid, output frame_ok, output pos_x, output pos_y,
                  output heading, input ready);
  modport sink (input valid, input frame_ok, input pos_x, input pos_y,
                input heading, output ready);
endinterface

// ===== rtl/core/cfd_crc_byte.sv =====
// CRC-16/XMODEM update by one byte, MSB first.
module cfd_crc_byte (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);
  import cfd_pkg::*;

  logic [15:0] c;

  always_comb begin
    c = crc_in ^ {data_in, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

// ===== rtl/core/cfd_parser.sv =====
// Frame tracker: position counter, header checks, payload capture and CRC.
module cfd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_take,
  input  logic [7:0]       rx_byte,
  output logic             res_valid,
  output cfd_pkg::result_t res_data
);
  import cfd_pkg::*;

  logic        in_frame;
  logic [3:0]  byte_index;
  logic [15:0] running_crc;
  logic        header_good;
  logic [15:0] held_x;
  logic [15:0] held_y;
  logic [15:0] held_heading;
  logic [15:0] crc_received;
  logic [15:0] crc_next;
  logic        ok;

  cfd_crc_byte u_crc (
    .crc_in  (running_crc),
    .data_in (rx_byte),
    .crc_out (crc_next)
  );

  assign ok = header_good && (running_crc == crc_received) && (rx_byte == END_BYTE);

  always_comb begin
    res_valid = byte_take && in_frame && (byte_index == POS_END);
    res_data.frame_ok = ok;
    res_data.pos_x    = ok ? held_x : 16'sd0;
    res_data.pos_y    = ok ? held_y : 16'sd0;
    res_data.heading  = ok ? held_heading : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      byte_index <= '0;
    end else if (byte_take) begin
      if (!in_frame) begin
        // hunt for start; clear the frame context on it
        if (rx_byte == START_BYTE) begin
          in_frame     <= 1'b1;
          byte_index   <= '0;
          running_crc  <= '0;
          header_good  <= 1'b1;
          held_x       <= '0;
          held_y       <= '0;
          held_heading <= '0;
          crc_received <= '0;
        end
      end else if (byte_index == POS_END) begin
        in_frame   <= 1'b0;
        byte_index <= '0;
      end else begin
        byte_index <= byte_index + 4'd1;
        case (byte_index)
          POS_ID, POS_ID_REP: begin
            if (rx_byte != FRAME_ID) header_good <= 1'b0;
          end
          POS_LEN: begin
            if (rx_byte != FRAME_LEN) header_good <= 1'b0;
          end
          POS_CRC_HI: crc_received[15:8] <= rx_byte;
          POS_CRC_LO: crc_received[7:0]  <= rx_byte;
          default: begin
            // payload positions feed the CRC
            running_crc <= crc_next;
            case (byte_index)
              POS_X_HI:   held_x[15:8]       <= rx_byte;
              POS_X_LO:   held_x[7:0]        <= rx_byte;
              POS_Y_HI:   held_y[15:8]       <= rx_byte;
              POS_Y_LO:   held_y[7:0]        <= rx_byte;
              POS_HDG_HI: held_heading[15:8] <= rx_byte;
              POS_HDG_LO: held_heading[7:0]  <= rx_byte;
              default: ;
            endcase
          end
        endcase
      end
    end
  end

endmodule

// ===== rtl/core/cfd_result_reg.sv =====
// Output register for decoded results with valid/ready handshake.
module cfd_result_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  cfd_pkg::result_t load_data,
  output logic             can_load,
  cfd_result_if.source     res
);
  import cfd_pkg::*;

  logic    held_valid;
  result_t held;

  // take new data when empty or when the held request leaves this cycle
  assign can_load = !held_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (can_load) begin
      held_valid <= load;
    end
    if (can_load && load) begin
      held <= load_data;
    end
  end

  assign res.valid    = held_valid;
  assign res.frame_ok = held.frame_ok;
  assign res.pos_x    = held.pos_x;
  assign res.pos_y    = held.pos_y;
  assign res.heading  = held.heading;

endmodule

// ===== rtl/core/coordinate_frame_deframer_unit.sv =====
// Coordinate frame deframer top level.
//
// rx carries one received byte per request. Bytes are dropped until the
// start byte 0x12; the next 11 bytes form a frame (id, length, six payload
// bytes, repeated id, big-endian CRC-16/XMODEM) and the byte after them
// must be the end byte 0x34. On that end position one request leaves on
// res: frame_ok plus x, y and heading, or all zero if anything mismatched.
//
// Throughput is one byte per cycle while rx.ready is high: the CRC update,
// position counter and checks are one byte-wide step between the frame
// state registers. The result is valid on res the cycle after the end
// byte is taken. A single output register holds the result; rx.ready
// drops only while that register is full and res.ready is low, so a stalled
// receiver holds the byte stream until it takes the pending request.
// Reset (rst, synchronous) returns to start-byte hunting and empties the
// output register.
module coordinate_frame_deframer_unit (
  input  logic         clk,
  input  logic         rst,
  cfd_byte_if.sink     rx,
  cfd_result_if.source res
);
  import cfd_pkg::*;

  logic    can_load;
  logic    byte_take;
  logic    res_valid;
  result_t res_data;

  assign rx.ready  = can_load;
  assign byte_take = rx.valid && can_load;

  cfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .byte_take (byte_take),
    .rx_byte   (rx.rx_byte),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  cfd_result_reg u_result (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .load_data (res_data),
    .can_load  (can_load),
    .res       (res)
  );

endmodule

// ===== bench/tb_coordinate_frame_deframer_unit.sv =====
// Self-checking testbench for the coordinate frame deframer: byte stream in, frame results out.
`timescale 1ns / 100ps

module tb_coordinate_frame_deframer_unit;
  import cfd_pkg::*;

  localparam int WATCHDOG_CYCLES = 3000;
  localparam int DRAIN_CYCLES    = 10;
  localparam int REPORT_LIMIT    = 10;
  localparam int FRAME_BYTE_GOAL = 800;

  typedef enum int {
    DMG_NONE, DMG_ID, DMG_LEN, DMG_ID_REP, DMG_CRC, DMG_END, DMG_SHORT
  } damage_e;

  logic clk;
  logic rst;

  cfd_byte_if   rx_ch ();
  cfd_result_if res_ch ();

  coordinate_frame_deframer_unit dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .res (res_ch)
  );

  logic [7:0] byte_queue [$];
  result_t    frames_expected [$];

  // Deframer state as seen by the predictor
  bit          in_frame   = 1'b0;
  logic [3:0]  frame_pos  = 4'd0;
  logic [15:0] crc_run    = 16'h0000;
  logic [15:0] crc_rcvd   = 16'h0000;
  bit          hdr_ok     = 1'b1;
  logic [15:0] x_word     = 16'h0000;
  logic [15:0] y_word     = 16'h0000;
  logic [15:0] hdg_word   = 16'h0000;

  bit rx_fire;
  bit res_fire;
  int rx_gap;
  int rx_calm;
  int res_stall;
  int res_calm;
  int idle_cycles;
  int errors;
  int results_checked;
  int results_ok;
  int frame_bytes;
  int frames_clean;
  int frames_damaged;
  result_t got;
  result_t want;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a calm stretch with none
  function automatic int draw_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] payload_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return START_BYTE;
    if (r < 8) return END_BYTE;
    if (r < 11) return FRAME_ID;
    if (r < 14) return 8'h00;
    if (r < 17) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    result_t r;
    if (!in_frame) begin
      if (b == START_BYTE) begin
        in_frame = 1'b1;
        frame_pos = 4'd0;
        crc_run = 16'h0000;
        crc_rcvd = 16'h0000;
        hdr_ok = 1'b1;
        x_word = 16'h0000;
        y_word = 16'h0000;
        hdg_word = 16'h0000;
      end
    end else if (frame_pos >= POS_END) begin
      r.frame_ok = hdr_ok && (crc_run == crc_rcvd) && (b == END_BYTE);
      r.pos_x    = r.frame_ok ? x_word : 16'h0000;
      r.pos_y    = r.frame_ok ? y_word : 16'h0000;
      r.heading  = r.frame_ok ? hdg_word : 16'h0000;
      frames_expected = {frames_expected, r};
      in_frame = 1'b0;
      frame_pos = 4'd0;
    end else begin
      case (frame_pos)
        POS_ID, POS_ID_REP: if (b != FRAME_ID) hdr_ok = 1'b0;
        POS_LEN:            if (b != FRAME_LEN) hdr_ok = 1'b0;
        POS_CRC_HI:         crc_rcvd[15:8] = b;
        POS_CRC_LO:         crc_rcvd[7:0] = b;
        default: begin
          crc_run = crc_step(crc_run, b);
          case (frame_pos)
            POS_X_HI:   x_word[15:8] = b;
            POS_X_LO:   x_word[7:0] = b;
            POS_Y_HI:   y_word[15:8] = b;
            POS_Y_LO:   y_word[7:0] = b;
            POS_HDG_HI: hdg_word[15:8] = b;
            POS_HDG_LO: hdg_word[7:0] = b;
            default: ;
          endcase
        end
      endcase
      frame_pos = frame_pos + 4'd1;
    end
  endtask

  task automatic queue_frame(input logic [7:0] pay [6], input damage_e dmg);
    logic [7:0]  f [13];
    logic [15:0] crc;
    int          cut;
    crc = 16'h0000;
    for (int i = 0; i < 6; i++) crc = crc_step(crc, pay[i]);
    f[0] = START_BYTE;
    f[1] = FRAME_ID;
    f[2] = FRAME_LEN;
    for (int i = 0; i < 6; i++) f[3 + i] = pay[i];
    f[9]  = FRAME_ID;
    f[10] = crc[15:8];
    f[11] = crc[7:0];
    f[12] = END_BYTE;
    cut = 13;
    case (dmg)
      DMG_ID:     f[1] ^= 8'($urandom_range(1, 255));
      DMG_LEN:    f[2] ^= 8'($urandom_range(1, 255));
      DMG_ID_REP: f[9] ^= 8'($urandom_range(1, 255));
      DMG_CRC: begin
        if ($urandom_range(0, 1) == 1) f[10] ^= 8'($urandom_range(1, 255));
        else f[11] ^= 8'($urandom_range(1, 255));
      end
      DMG_END:    f[12] ^= 8'($urandom_range(1, 255));
      // cut the frame off; the next start byte lands inside it as data
      DMG_SHORT:  cut = $urandom_range(2, 12);
      default: ;
    endcase
    for (int i = 0; i < cut; i++) byte_queue = {byte_queue, f[i]};
    frame_bytes += cut;
    if (dmg == DMG_NONE) frames_clean++;
    else frames_damaged++;
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = 8'h00;
    res_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
  end

  // Sender: hold each request until it is taken, then advance with a random gap
  always @(negedge clk) begin
    if (rst) begin
      rx_ch.valid <= 1'b0;
    end else if (!rx_ch.valid || rx_fire) begin
      if (rx_gap > 0) begin
        rx_ch.valid <= 1'b0;
        rx_gap--;
      end else if (byte_queue.size() != 0) begin
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= byte_queue.pop_front();
        rx_gap = draw_gap(rx_calm);
      end else begin
        rx_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (res_stall > 0) begin
      res_ch.ready <= 1'b0;
      res_stall--;
    end else begin
      res_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) res_stall = draw_gap(res_calm);
    end
  end

  always @(posedge clk) begin
    rx_fire  = !rst && rx_ch.valid && rx_ch.ready;
    res_fire = !rst && res_ch.valid && res_ch.ready;

    if (res_fire) begin
      got.frame_ok = res_ch.frame_ok;
      got.pos_x    = res_ch.pos_x;
      got.pos_y    = res_ch.pos_y;
      got.heading  = res_ch.heading;
      if (frames_expected.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("unexpected result: ok=%0b x=%0d y=%0d heading=%0d",
                   got.frame_ok, got.pos_x, got.pos_y, got.heading);
      end else begin
        want = frames_expected.pop_front();
        results_checked++;
        if (want.frame_ok) results_ok++;
        if (got.frame_ok !== want.frame_ok || got.pos_x !== want.pos_x ||
            got.pos_y !== want.pos_y || got.heading !== want.heading) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("result %0d: want ok=%0b x=%0d y=%0d hdg=%0d, got ok=%0b x=%0d y=%0d hdg=%0d",
                     results_checked, want.frame_ok, want.pos_x, want.pos_y,
                     want.heading, got.frame_ok, got.pos_x, got.pos_y, got.heading);
        end
      end
    end

    if (rx_fire) deframe_byte(rx_ch.rx_byte);

    if (rst || rx_fire || res_fire) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("watchdog: no request moved for %0d cycles", WATCHDOG_CYCLES);
        $display("tb_coordinate_frame_deframer_unit: done, errors");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] pay [6];
    int         pick;
    int         burst;
    logic [7:0] b;

    // idle bytes, a clean frame at the field extremes, then a frame carrying
    // start and end bytes as payload and a bad end byte
    byte_queue = {byte_queue, 8'h00};
    byte_queue = {byte_queue, 8'hFF};
    pay = '{8'h7F, 8'hFF, 8'h80, 8'h00, 8'hFF, 8'hFF};
    queue_frame(pay, DMG_NONE);
    pay = '{START_BYTE, END_BYTE, START_BYTE, END_BYTE, 8'h00, 8'h00};
    queue_frame(pay, DMG_END);

    while (frame_bytes < FRAME_BYTE_GOAL) begin
      pick = $urandom_range(0, 99);
      if (pick < 88) begin
        for (int i = 0; i < 6; i++) pay[i] = payload_byte();
        if (pick < 65) queue_frame(pay, DMG_NONE);
        else queue_frame(pay, damage_e'($urandom_range(int'(DMG_ID), int'(DMG_SHORT))));
      end else begin
        burst = $urandom_range(1, 6);
        for (int i = 0; i < burst; i++) begin
          b = 8'($urandom_range(0, 255));
          if (b == START_BYTE && $urandom_range(0, 3) != 0) b = 8'h00;
          byte_queue = {byte_queue, b};
        end
      end
    end

    while (byte_queue.size() != 0 || rx_ch.valid) @(posedge clk);
    while (frames_expected.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (frames_expected.size() != 0) begin
      errors += frames_expected.size();
      $display("%0d expected results never arrived", frames_expected.size());
    end
    $display("sent %0d frames (%0d clean, %0d damaged or cut short) in %0d frame bytes",
             frames_clean + frames_damaged, frames_clean, frames_damaged, frame_bytes);
    $display("checked %0d results, %0d of them good frames; %0d errors",
             results_checked, results_ok, errors);
    if (errors == 0) begin
      $display("tb_coordinate_frame_deframer_unit: done, clean");
    end else begin
      $display("tb_coordinate_frame_deframer_unit: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/cfd_pkg.sv
rtl/core/cfd_channels.sv
rtl/core/cfd_crc_byte.sv
rtl/core/cfd_parser.sv
rtl/core/cfd_result_reg.sv
rtl/core/coordinate_frame_deframer_unit.sv
bench/tb_coordinate_frame_deframer_unit.sv
